[src/mpq_pkg.sv]
`timescale 1ns / 1ps

package mpq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS    = VALUE_WIDTH + 1 + COUNT_W + 1;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [COUNT_W-1:0]            t_count;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef struct packed {
        logic   en;
        logic   pop;
        t_value value;
    } t_cell_ctrl;

endpackage

[src/mpq_cell.sv]
`timescale 1ns / 1ps

module mpq_cell
    import mpq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  t_value     i_left_value,
    input  logic       i_left_ins,
    input  t_value     i_right_value,
    output t_value     o_value,
    output logic       o_ins,
    output t_value     o_next_value
);

    t_value r_value;
    t_value n_value;
    logic   ins;

    // this cell takes the new value or the shifted one on a push
    assign ins = !i_occupied || (i_ctrl.value < r_value);

    always_comb begin
        n_value = r_value;
        if (i_ctrl.en) begin
            if (i_ctrl.pop) begin
                n_value = i_right_value;
            end else if (ins) begin
                n_value = i_left_ins ? i_left_value : i_ctrl.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_ins        = ins;
    assign o_next_value = n_value;

endmodule

[src/min_priority_queue.sv]
`timescale 1ns / 1ps
// min_priority_queue: bounded min-priority queue of signed values
// slave channel: tuser is the request kind (0 push, 1 pop), tdata the value
// master channel: one result word per request with the smallest entry after
// the request (0 when empty), the empty flag, the entry count and a flag for
// a push dropped because the queue was full
// the entries sit in a row of cells kept in ascending order; every cell
// compares the pushed value with its own entry in the same cycle and takes
// its own, its left neighbor's or the new value, or on a pop its right
// neighbor's value
// the result word is registered and valid in the cycle after the request is accepted
// throughput: one request per cycle while the receiver takes each result word, set by the single compare per cell
// reset clears the entry count and the output valid; cell contents are
// not cleared
// when the receiver stalls the result word holds, and a new request is taken
// only in a cycle where the held word leaves
module min_priority_queue
    import mpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // value
    input  logic                  i_s_tuser,   // req_type
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // top_value, is_empty, entry_count, push_dropped
);

    t_count     r_count;
    t_count     n_count;
    logic       r_valid;
    t_value     r_top;
    logic       r_empty;
    logic       r_dropped;
    t_cell_ctrl ctrl;
    logic       accept;
    logic       full;
    logic       push_ok;
    logic       pop_ok;

    t_value cell_value [CAPACITY];
    t_value cell_next  [CAPACITY];
    logic   cell_ins   [CAPACITY];

    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign full       = (r_count == t_count'(CAPACITY));
    assign push_ok    = (t_req'(i_s_tuser) == REQ_PUSH) && !full;
    assign pop_ok     = (t_req'(i_s_tuser) == REQ_POP) && (r_count != '0);

    assign ctrl.en    = accept && (push_ok || pop_ok);
    assign ctrl.pop   = (t_req'(i_s_tuser) == REQ_POP);
    assign ctrl.value = t_value'(i_s_tdata[VALUE_WIDTH-1:0]);

    always_comb begin
        n_count = r_count;
        if (ctrl.en) begin
            n_count = ctrl.pop ? r_count - t_count'(1) : r_count + t_count'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        mpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (t_count'(i) < r_count),
            .i_left_value  ((i == 0) ? ctrl.value : cell_value[(i == 0) ? 0 : i - 1]),
            .i_left_ins    ((i == 0) ? 1'b0 : cell_ins[(i == 0) ? 0 : i - 1]),
            .i_right_value ((i == CAPACITY - 1) ? ctrl.value
                            : cell_value[(i == CAPACITY - 1) ? i : i + 1]),
            .o_value       (cell_value[i]),
            .o_ins         (cell_ins[i]),
            .o_next_value  (cell_next[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top     <= (n_count != '0) ? cell_next[0] : '0;
            r_empty   <= (n_count == '0);
            r_dropped <= !ctrl.pop && full;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_dropped, r_count, r_empty, r_top});

endmodule

[src/mpq_checker.sv]
`timescale 1ns / 1ps

module mpq_checker
    import mpq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata
);

    t_value top_value;
    logic   is_empty;
    t_count entry_count;
    logic   push_dropped;

    assign top_value    = t_value'(o_m_tdata[VALUE_WIDTH-1:0]);
    assign is_empty     = o_m_tdata[VALUE_WIDTH];
    assign entry_count  = o_m_tdata[VALUE_WIDTH+COUNT_W:VALUE_WIDTH+1];
    assign push_dropped = o_m_tdata[VALUE_WIDTH+COUNT_W+1];

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && is_empty |-> (top_value == '0))
        else $error("empty queue shows nonzero top");

    a_dropped_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && push_dropped |-> (entry_count == t_count'(CAPACITY)))
        else $error("push dropped while not full");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (t_req'(i_s_tuser) == REQ_POP)
        |=> o_m_tvalid && !push_dropped)
        else $error("pop word missing or flagged as dropped push");

endmodule

bind min_priority_queue mpq_checker u_mpq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
